@@ rtl/core/crfe_pkg.sv @@
// ----------------------------------------------------------------------------
// crfe_pkg: shared types and constants of the rectangle fill engine
// Request codes, payload widths and the sequencer state type.
// ----------------------------------------------------------------------------
package crfe_pkg;

	// Payload widths fixed by the request and result formats.
	localparam int COORD_W   = 16;
	localparam int COLOR_W   = 16;
	localparam int BAND_BITS = 51;
	localparam int FRAME_W   = 32;

	// Request codes.
	localparam logic [1:0] REQ_FILL  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_FLUSH = 2'd2;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CLIP_LO,
		ST_CLIP_HI,
		ST_TEST,
		ST_DIV,
		ST_READ_CHK,
		ST_MUL,
		ST_ADD,
		ST_FILL,
		ST_READ,
		ST_READ_WAIT,
		ST_FLUSH,
		ST_RESP
	} crfe_state_t;

endpackage

@@ rtl/core/crfe_intf.sv @@
// ----------------------------------------------------------------------------
// crfe_intf: request and result channels of the rectangle fill engine
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface crfe_req_if import crfe_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic [1:0]                req_type;
	logic signed [COORD_W-1:0] pos_x;
	logic signed [COORD_W-1:0] pos_y;
	logic signed [COORD_W-1:0] rect_width;
	logic signed [COORD_W-1:0] rect_height;
	logic [COLOR_W-1:0]        fill_color;
	logic                      read_buffer;

	modport source (
		output valid, req_type, pos_x, pos_y, rect_width, rect_height,
		       fill_color, read_buffer,
		input  ready
	);
	modport sink (
		input  valid, req_type, pos_x, pos_y, rect_width, rect_height,
		       fill_color, read_buffer,
		output ready
	);
endinterface

interface crfe_rsp_if import crfe_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [COLOR_W-1:0]   pixel_value;
	logic                 bad_read;
	logic [BAND_BITS-1:0] dirty_bands;
	logic [FRAME_W-1:0]   frame_count;

	modport source (
		output valid, pixel_value, bad_read, dirty_bands, frame_count,
		input  ready
	);
	modport sink (
		input  valid, pixel_value, bad_read, dirty_bands, frame_count,
		output ready
	);
endinterface

@@ rtl/core/crfe_ram.sv @@
// ----------------------------------------------------------------------------
// crfe_ram: generic RAM with one write port and one registered read port
// Write and read addresses are independent; read data appears in the cycle after the read.
// ----------------------------------------------------------------------------
module crfe_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/clipped_rect_fill_engine.sv @@
// ----------------------------------------------------------------------------
// clipped_rect_fill_engine: double-buffered RGB565 framebuffer with clipped fill
// Fill, pixel read and flush/swap requests, one result beat per request.
// ----------------------------------------------------------------------------
// A fill writes one pixel per cycle through the single frame store write port.
// One request is in work at a time; the next is taken in the cycle after its
// result loads, which waits while an earlier result beat is stalled.
// After reset a clearing pass writes zero to all 2*W*H pixels, one per cycle,
// while no request is taken.
module clipped_rect_fill_engine import crfe_pkg::*; #(
	parameter int SCREEN_WIDTH  = 480,
	parameter int SCREEN_HEIGHT = 800,
	parameter int BAND_ROWS     = 16
) (
	input  logic clk,
	input  logic arst_n,
	crfe_req_if.sink   req,
	crfe_rsp_if.source rsp
);

	localparam int XW         = $clog2(SCREEN_WIDTH + 1);
	localparam int YW         = $clog2(SCREEN_HEIGHT + 1);
	localparam int PLANE      = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int DEPTH      = 2 * PLANE;
	localparam int AW         = $clog2(DEPTH);
	localparam int RW         = $clog2(BAND_ROWS) + 2;
	localparam int CW         = COORD_W + 3;
	localparam int BAND_COUNT = SCREEN_HEIGHT / BAND_ROWS + 1;
	localparam int BAND_SLOTS = (BAND_COUNT < BAND_BITS) ? BAND_COUNT : BAND_BITS;
	localparam logic [BAND_BITS-1:0] BAND_MASK =
		{BAND_BITS{1'b1}} >> (BAND_BITS - BAND_SLOTS);

	// Reciprocal of the band height, exact for every row index below 2**YW.
	localparam int BAND_SHIFT = YW + $clog2(BAND_ROWS);
	localparam int BAND_RECIP = (2 ** BAND_SHIFT + BAND_ROWS - 1) / BAND_ROWS;
	localparam int QW         = BAND_SHIFT + YW;

	crfe_state_t state_q, state_d;

	// Captured request.
	logic [1:0]                type_q;
	logic signed [COORD_W-1:0] px_q, py_q, pw_q, ph_q;
	logic [COLOR_W-1:0]        color_q;
	logic                      rbuf_q;

	// Clipped rectangle or read coordinates.
	logic signed [CW-1:0] cx_q, cy_q, cw_q, ch_q;

	// Band index and row within the band, later the band walker.
	logic [YW-1:0]  dvd_q;
	logic [RW-1:0]  rem_q;

	// Addressing and fill counters.
	logic [AW-1:0] prod_q, addr_q, row_q;
	logic [XW-1:0] col_q;
	logic [YW-1:0] rowc_q;

	// Architectural state.
	logic                 draw_q;
	logic [BAND_BITS-1:0] band_dirty_q;
	logic [FRAME_W-1:0]   frames_q;

	// Pending result and output register.
	logic [COLOR_W-1:0]   res_pixel_q;
	logic                 res_bad_q;
	logic [BAND_BITS-1:0] res_dirty_q;
	logic                 out_valid_q;
	logic [COLOR_W-1:0]   out_pixel_q;
	logic                 out_bad_q;
	logic [BAND_BITS-1:0] out_dirty_q;
	logic [FRAME_W-1:0]   out_frames_q;

	// Frame store port signals.
	logic                 ram_we, ram_re;
	logic [COLOR_W-1:0]   ram_wdata, ram_rdata;

	// Combinational helpers.
	logic signed [CW-1:0] px_e, py_e, pw_e, ph_e;
	logic signed [CW-1:0] x_end, y_end;
	logic                 fill_empty, read_bad;
	logic [QW-1:0]        band_prod;
	logic [YW-1:0]        band_base;
	logic                 row_end, fill_last;
	logic                 plane_sel;
	logic [BAND_BITS-1:0] band_mark;
	logic                 is_fill, load_out, accept;

	// Sign-extended request fields and clip sums.
	assign px_e  = CW'(px_q);
	assign py_e  = CW'(py_q);
	assign pw_e  = CW'(pw_q);
	assign ph_e  = CW'(ph_q);
	assign x_end = cx_q + cw_q;
	assign y_end = cy_q + ch_q;

	assign fill_empty = cw_q[CW-1] || (cw_q == '0) || ch_q[CW-1] || (ch_q == '0);
	assign read_bad   = px_q[COORD_W-1] || (px_q >= COORD_W'(SCREEN_WIDTH)) ||
	                    py_q[COORD_W-1] || (py_q >= COORD_W'(SCREEN_HEIGHT));

	// Band of the top row by reciprocal multiplication, and the first row of
	// that band for the row-within-band remainder.
	assign band_prod = QW'(cy_q[YW-1:0]) * QW'(BAND_RECIP);
	assign band_base = dvd_q * YW'(BAND_ROWS);

	// Fill walk: end of row and end of rectangle.
	assign row_end   = (col_q == cw_q[XW-1:0] - XW'(1));
	assign fill_last = row_end && (rowc_q == ch_q[YW-1:0] - YW'(1));
	assign band_mark = BAND_MASK & (BAND_BITS'(1) << dvd_q);

	assign is_fill   = (type_q == REQ_FILL);
	assign plane_sel = is_fill ? draw_q : (draw_q ^ rbuf_q);
	assign accept    = req.valid && req.ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (addr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req.valid) begin
					unique case (req.req_type)
						REQ_FILL:  state_d = ST_CLIP_LO;
						REQ_READ:  state_d = ST_READ_CHK;
						REQ_FLUSH: state_d = ST_FLUSH;
						default:   state_d = ST_RESP;
					endcase
				end
			end
			ST_CLIP_LO:   state_d = ST_CLIP_HI;
			ST_CLIP_HI:   state_d = ST_TEST;
			ST_TEST:      state_d = fill_empty ? ST_RESP : ST_DIV;
			ST_DIV:       state_d = ST_MUL;
			ST_READ_CHK:  state_d = read_bad ? ST_RESP : ST_MUL;
			ST_MUL:       state_d = ST_ADD;
			ST_ADD:       state_d = is_fill ? ST_FILL : ST_READ;
			ST_FILL: begin
				if (fill_last) state_d = ST_RESP;
			end
			ST_READ:      state_d = ST_READ_WAIT;
			ST_READ_WAIT: state_d = ST_RESP;
			ST_FLUSH:     state_d = ST_RESP;
			ST_RESP: begin
				if (!out_valid_q || rsp.ready) state_d = ST_IDLE;
			end
			default:      state_d = ST_CLEAR;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		req.ready = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_wdata = color_q;
		load_out  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_wdata = '0;
			end
			ST_IDLE:  req.ready = 1'b1;
			ST_FILL:  ram_we    = 1'b1;
			ST_READ:  ram_re    = 1'b1;
			ST_RESP:  load_out  = !out_valid_q || rsp.ready;
			default: begin
			end
		endcase
	end

	// Control and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			addr_q       <= '0;
			draw_q       <= 1'b0;
			band_dirty_q <= BAND_MASK;
			frames_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_CLEAR: addr_q <= addr_q + AW'(1);
				ST_ADD: begin
					addr_q <= (plane_sel ? AW'(PLANE) : AW'(0)) + prod_q +
					          AW'(cx_q[XW-1:0]);
				end
				ST_FILL: begin
					band_dirty_q <= band_dirty_q | band_mark;
					if (row_end) begin
						addr_q <= row_q + AW'(SCREEN_WIDTH);
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				ST_FLUSH: begin
					band_dirty_q <= '0;
					draw_q       <= ~draw_q;
					frames_q     <= frames_q + FRAME_W'(1);
				end
				default: begin
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			type_q      <= req.req_type;
			px_q        <= req.pos_x;
			py_q        <= req.pos_y;
			pw_q        <= req.rect_width;
			ph_q        <= req.rect_height;
			color_q     <= req.fill_color;
			rbuf_q      <= req.read_buffer;
			res_pixel_q <= '0;
			res_bad_q   <= 1'b0;
			res_dirty_q <= '0;
		end
		unique case (state_q)
			// Clip the left and top edges.
			ST_CLIP_LO: begin
				cx_q <= px_e[CW-1] ? CW'(0) : px_e;
				cw_q <= px_e[CW-1] ? (pw_e + px_e) : pw_e;
				cy_q <= py_e[CW-1] ? CW'(0) : py_e;
				ch_q <= py_e[CW-1] ? (ph_e + py_e) : ph_e;
			end
			// Clip the right and bottom edges.
			ST_CLIP_HI: begin
				if (x_end > CW'(SCREEN_WIDTH)) cw_q <= CW'(SCREEN_WIDTH) - cx_q;
				if (y_end > CW'(SCREEN_HEIGHT)) ch_q <= CW'(SCREEN_HEIGHT) - cy_q;
			end
			// Band index of the top row.
			ST_DIV: dvd_q <= band_prod[BAND_SHIFT +: YW];
			ST_READ_CHK: begin
				cx_q      <= px_e;
				cy_q      <= py_e;
				res_bad_q <= read_bad;
			end
			// Row offset, and the top row's position within its band.
			ST_MUL: begin
				prod_q <= AW'(cy_q[YW-1:0]) * AW'(SCREEN_WIDTH);
				rem_q  <= RW'(cy_q[YW-1:0] - band_base);
			end
			ST_ADD: begin
				row_q  <= (plane_sel ? AW'(PLANE) : AW'(0)) + prod_q +
				          AW'(cx_q[XW-1:0]);
				col_q  <= '0;
				rowc_q <= '0;
			end
			// Walk the rectangle; the band index follows the row.
			ST_FILL: begin
				if (row_end) begin
					col_q  <= '0;
					rowc_q <= rowc_q + YW'(1);
					row_q  <= row_q + AW'(SCREEN_WIDTH);
					if (rem_q == RW'(BAND_ROWS - 1)) begin
						rem_q <= '0;
						dvd_q <= dvd_q + YW'(1);
					end else begin
						rem_q <= rem_q + RW'(1);
					end
				end else begin
					col_q <= col_q + XW'(1);
				end
			end
			ST_READ_WAIT: res_pixel_q <= ram_rdata;
			ST_FLUSH:     res_dirty_q <= band_dirty_q;
			default: begin
			end
		endcase
		if (load_out) begin
			out_pixel_q  <= res_pixel_q;
			out_bad_q    <= res_bad_q;
			out_dirty_q  <= res_dirty_q;
			out_frames_q <= frames_q;
		end
	end

	// Result channel.
	assign rsp.valid       = out_valid_q;
	assign rsp.pixel_value = out_pixel_q;
	assign rsp.bad_read    = out_bad_q;
	assign rsp.dirty_bands = out_dirty_q;
	assign rsp.frame_count = out_frames_q;

	// Frame store: both buffers in one memory, the second one W*H words above the first.
	crfe_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (DEPTH)
	) u_frame_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

endmodule

@@ rtl/core/crfe_checker.sv @@
// ----------------------------------------------------------------------------
// crfe_checker: port-level checks of the rectangle fill engine
// Watches the request and result channels; bound to the top level below.
// ----------------------------------------------------------------------------
module crfe_checker import crfe_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_ready,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input logic [COLOR_W-1:0]   pixel_value,
	input logic                 bad_read,
	input logic [BAND_BITS-1:0] dirty_bands,
	input logic [FRAME_W-1:0]   frame_count
);

	// A stalled result beat holds its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(pixel_value) &&
		$stable(bad_read) && $stable(dirty_bands) && $stable(frame_count))
		else $error("result beat changed while stalled");

	// One request at a time: a request beat closes the input side.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in work");

	// An off-screen read returns no pixel.
	a_bad_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && bad_read |-> pixel_value == '0)
		else $error("bad read carries a pixel value");

	// A flush result carries only the band mask and the frame count.
	a_flush_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (dirty_bands != '0) |-> !bad_read && (pixel_value == '0))
		else $error("flush result mixed with read fields");

endmodule

bind clipped_rect_fill_engine crfe_checker u_crfe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.pixel_value (rsp.pixel_value),
	.bad_read    (rsp.bad_read),
	.dirty_bands (rsp.dirty_bands),
	.frame_count (rsp.frame_count)
);
